// ----- sv/qdd_pkg.sv -----
// Package: shared types, constants and helpers for the quadrature detent decoder.
package qdd_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int TIME_W     = 32;
  localparam int POS_W      = 16;
  localparam int ACC_W      = 4;
  localparam int THR_W      = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_THRESH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_DIR   = 2'd2;

  localparam logic [15:0]      RST_IDLE_TIMEOUT = 16'd500;
  localparam logic [THR_W-1:0] RST_STEP_THRESH  = 3'd2;
  localparam logic             RST_INVERT_DIR   = 1'b1;
  localparam logic [THR_W-1:0] THRESH_MAX       = 3'd6;

  typedef struct packed {
    logic [15:0]      idle_timeout_ms;
    logic [THR_W-1:0] step_threshold;
    logic             invert_direction;
  } qdd_cfg_t;

  typedef struct packed {
    logic              chan_a;
    logic              chan_b;
    logic              button_in;
    logic [TIME_W-1:0] now_ms;
  } qdd_item_t;

  // Gray phase of the A/B pair: 00->0, 01->1, 11->2, 10->3
  function automatic logic [1:0] gray_phase(input logic a, input logic b);
    gray_phase = {a, a ^ b};
  endfunction

endpackage

// ----- sv/qdd_in_if.sv -----
// Interface: encoder poll channel.
interface qdd_in_if import qdd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              chan_a;
  logic              chan_b;
  logic              button_in;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, chan_a, chan_b, button_in, now_ms, input ready);
  modport sink   (input valid, chan_a, chan_b, button_in, now_ms, output ready);
endinterface

// ----- sv/qdd_out_if.sv -----
// Interface: position result channel.
interface qdd_out_if import qdd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] wheel_position;
  logic                    button_pressed;

  modport source (output valid, wheel_position, button_pressed, input ready);
  modport sink   (input valid, wheel_position, button_pressed, output ready);
endinterface

// ----- sv/qdd_cfg_if.sv -----
// Interface: configuration write channel.
interface qdd_cfg_if import qdd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ----- sv/quadrature_detent_decoder_unit.sv -----
// Top level: rotary encoder poll decoder with 16-bit wrapping detent position.
//
//  channel | dir | handshake      | payload
//  --------+-----+----------------+------------------------------------------
//  in_if   | in  | valid / ready  | chan_a, chan_b, button_in, now_ms[31:0]
//  out_if  | out | valid / ready  | wheel_position[15:0] (signed), button_pressed
//  cfg_if  | in  | valid / ready  | reg_index[1:0], wdata[15:0]
//
//  One poll per cycle sustained while out_if is ready. The poll is captured
//  in the input register, then decoded against the state registers in one pass
//  and written to the result register along with the state update.
//  Reset (rst_n low, synchronous) zeroes phase, accumulator, last-step time and
//  position, and loads timeout 500 ms, threshold 2, inverted direction.
//  A stall on out_if holds the result register; the input register then
//  fills and in_if.ready drops. cfg_if is always ready.
module quadrature_detent_decoder_unit import qdd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  qdd_in_if.sink    in_if,
  qdd_out_if.source out_if,
  qdd_cfg_if.sink   cfg_if
);

  // configuration registers
  qdd_cfg_t cfg_r;

  // input register
  logic      in_valid_r;
  qdd_item_t in_item_r;

  // result register
  logic                    out_valid_r;
  logic signed [POS_W-1:0] out_pos_r;
  logic                    out_btn_r;

  logic                    advance;   // input register moves into the result register
  logic                    in_take;
  logic signed [POS_W-1:0] position_nxt;

  assign advance      = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !in_valid_r || advance;
  assign in_take      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  assign out_if.valid          = out_valid_r;
  assign out_if.wheel_position = out_pos_r;
  assign out_if.button_pressed = out_btn_r;

  // configuration writes; indexes outside the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.idle_timeout_ms  <= RST_IDLE_TIMEOUT;
      cfg_r.step_threshold   <= RST_STEP_THRESH;
      cfg_r.invert_direction <= RST_INVERT_DIR;
    end else if (cfg_if.valid && cfg_if.ready) begin
      unique case (cfg_if.reg_index)
        REG_IDLE_TIMEOUT: cfg_r.idle_timeout_ms  <= cfg_if.wdata;
        REG_STEP_THRESH:  cfg_r.step_threshold   <= cfg_if.wdata[THR_W-1:0];
        REG_INVERT_DIR:   cfg_r.invert_direction <= cfg_if.wdata[0];
        default: ;
      endcase
    end
  end

  // input register: valid bit under reset, payload loads on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.chan_a    <= in_if.chan_a;
      in_item_r.chan_b    <= in_if.chan_b;
      in_item_r.button_in <= in_if.button_in;
      in_item_r.now_ms    <= in_if.now_ms;
    end
  end

  qdd_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .item         (in_item_r),
    .cfg          (cfg_r),
    .position_nxt (position_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_if.ready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pos_r <= position_nxt;
      out_btn_r <= in_item_r.button_in;
    end
  end

  // a processed poll always lands in the result register
  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed poll lost");

  // a poll waiting in the input register is not dropped
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> in_valid_r)
    else $error("pending poll dropped");

  // input register only advances when the result side has room
  a_adv_room: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && out_valid_r) |-> out_if.ready)
    else $error("result overwritten while stalled");

endmodule

// ----- sv/qdd_core.sv -----
// Step decode, idle timeout, accumulator and detent position state.
module qdd_core import qdd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    advance,
  input  qdd_item_t               item,
  input  qdd_cfg_t                cfg,
  output logic signed [POS_W-1:0] position_nxt
);

  logic        [1:0]        prev_phase_r;
  logic signed [ACC_W-1:0]  step_accum_r, step_accum_nxt;
  logic        [TIME_W-1:0] last_time_r, last_time_nxt;
  logic signed [POS_W-1:0]  position_r;

  logic        [1:0]        phase;
  logic                     step_nz, step_back;
  logic signed [ACC_W-1:0]  step, sum;
  logic        [ACC_W-1:0]  mag;
  logic        [THR_W-1:0]  thr;
  logic        [TIME_W-1:0] elapsed;
  logic                     timed_out, up;

  always_comb begin
    phase     = gray_phase(item.chan_a, item.chan_b);
    step_nz   = (phase != prev_phase_r);
    step_back = step_nz && (phase == (prev_phase_r - 2'd1));
    step      = step_back ? -4'sd1 : (step_nz ? 4'sd1 : 4'sd0);
    thr       = (cfg.step_threshold > THRESH_MAX) ? THRESH_MAX : cfg.step_threshold;

    last_time_nxt = step_nz ? item.now_ms : last_time_r;
    elapsed       = item.now_ms - last_time_nxt;   // wraps mod 2^32
    timed_out     = (elapsed > {{(TIME_W-16){1'b0}}, cfg.idle_timeout_ms});

    sum  = step_accum_r + step;
    mag  = sum[ACC_W-1] ? ACC_W'(-sum) : ACC_W'(sum);
    up   = (!sum[ACC_W-1] && (sum != 4'sd0)) ^ cfg.invert_direction;

    step_accum_nxt = sum;
    position_nxt   = position_r;
    if (timed_out) begin
      step_accum_nxt = '0;
    end else if (mag > {1'b0, thr}) begin
      position_nxt   = up ? position_r + 16'sd1 : position_r - 16'sd1;
      step_accum_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_phase_r <= '0;
      step_accum_r <= '0;
      last_time_r  <= '0;
      position_r   <= '0;
    end else if (advance) begin
      prev_phase_r <= phase;
      step_accum_r <= step_accum_nxt;
      last_time_r  <= last_time_nxt;
      position_r   <= position_nxt;
    end
  end

  // accumulator never reaches -8 since the threshold is clamped to 6
  a_accum_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_accum_r != 4'sb1000)
    else $error("step accumulator out of range");

  // position only changes on a processed poll, by at most one detent
  a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(position_r))
    else $error("position moved without a poll");

  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (position_r == $past(position_r)) ||
                (position_r == $past(position_r) + 16'sd1) ||
                (position_r == $past(position_r) - 16'sd1))
    else $error("position moved by more than one detent");

endmodule

// ----- dv/tb_quadrature_detent_decoder_unit.sv -----
// Testbench for the quadrature detent decoder: predicts each poll's position, checks every result.
module tb_quadrature_detent_decoder_unit import qdd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Cycle budget: a run that hangs ends here once the budget is spent.
  localparam int CYCLE_LIMIT  = 300000;
  // Result side lags the poll side by the input and result registers; drain more for margin.
  localparam int DRAIN_CYCLES = 6;
  // Unused register slot: writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic signed [POS_W-1:0] wheel_position;
    logic                    button_pressed;
  } detent_result_t;

  // Detent predictor plus queue of positions still owed by the block.
  class detent_scoreboard;
    // configuration copy
    logic [15:0]      timeout_ms;
    logic [THR_W-1:0] threshold;
    logic             invert;
    // decoder state copy
    logic [1:0]              last_phase;
    int                      partial_steps;
    logic [TIME_W-1:0]       last_move_ms;
    logic signed [POS_W-1:0] detent_pos;

    detent_result_t expected_results[$];
    int             mismatches;

    function new();
      timeout_ms    = RST_IDLE_TIMEOUT;
      threshold     = RST_STEP_THRESH;
      invert        = RST_INVERT_DIR;
      last_phase    = 2'd0;
      partial_steps = 0;
      last_move_ms  = '0;
      detent_pos    = '0;
      mismatches    = 0;
    endfunction

    task report_mismatch(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_IDLE_TIMEOUT: timeout_ms = data[15:0];
        REG_STEP_THRESH:  threshold  = data[THR_W-1:0];
        REG_INVERT_DIR:   invert     = data[0];
        default: ;
      endcase
    endfunction

    // Decode one accepted poll and queue the position it must produce.
    function void note_poll(logic a, logic b, logic btn, logic [TIME_W-1:0] stamp);
      logic [1:0]        phase;
      logic [1:0]        one_back;
      logic [TIME_W-1:0] elapsed;
      int                step;
      int                limit;
      int                mag;
      logic              up;
      detent_result_t    res;
      case ({a, b})
        2'b00:   phase = 2'd0;
        2'b01:   phase = 2'd1;
        2'b11:   phase = 2'd2;
        default: phase = 2'd3;
      endcase
      one_back = last_phase - 2'd1;
      if (phase == last_phase) step = 0;
      else if (phase == one_back) step = -1;
      else step = 1;   // forward, or an illegal two-phase jump
      limit = (threshold > THRESH_MAX) ? int'(THRESH_MAX) : int'(threshold);
      if (step != 0) last_move_ms = stamp;
      elapsed = stamp - last_move_ms;
      if (elapsed > {16'd0, timeout_ms}) begin
        partial_steps = 0;
      end else begin
        partial_steps += step;
        mag = (partial_steps < 0) ? -partial_steps : partial_steps;
        if (mag > limit) begin
          up = (partial_steps > 0);
          if (invert) up = !up;
          detent_pos = up ? detent_pos + 16'sd1 : detent_pos - 16'sd1;
          partial_steps = 0;
        end
      end
      last_phase = phase;
      res.wheel_position = detent_pos;
      res.button_pressed = btn;
      expected_results.push_back(res);
    endfunction

    task check_result(logic signed [POS_W-1:0] pos, logic btn);
      detent_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with no poll pending: pos=%0d btn=%0b", pos, btn));
        return;
      end
      want = expected_results.pop_front();
      if (pos !== want.wheel_position)
        report_mismatch($sformatf("wheel_position got %0d want %0d",
                                  pos, want.wheel_position));
      if (btn !== want.button_pressed)
        report_mismatch($sformatf("button_pressed got %0b want %0b",
                                  btn, want.button_pressed));
    endtask

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  qdd_in_if  in_if();
  qdd_out_if out_if();
  qdd_cfg_if cfg_if();

  quadrature_detent_decoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  detent_scoreboard sb;

  int                send_idle_pct;
  int                recv_idle_pct;
  int                cycle_count;
  logic [1:0]        sent_phase;    // phase of the last poll transferred
  logic [TIME_W-1:0] clock_ms;      // timestamp of the last poll transferred
  int                run_dir;
  int                run_left;

  // Clock: 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run guard: a hang anywhere ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side backpressure, redrawn every cycle at the falling edge.
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Result monitor: sample on the rising edge, compare against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.wheel_position, out_if.button_pressed);
  end

  // Gray lines for a phase, as {A, B}.
  function automatic logic [1:0] lines_for_phase(logic [1:0] phase);
    case (phase)
      2'd0:    return 2'b00;
      2'd1:    return 2'b01;
      2'd2:    return 2'b11;
      default: return 2'b10;
    endcase
  endfunction

  // One poll transfer. Valid is left high afterwards so back-to-back polls never
  // see a low pulse; the next call or wait_idle decides what happens next.
  task automatic send_poll(logic [1:0] phase, logic btn, logic [TIME_W-1:0] stamp);
    logic [1:0] ab;
    ab = lines_for_phase(phase);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.chan_a    <= ab[1];
    in_if.chan_b    <= ab[0];
    in_if.button_in <= btn;
    in_if.now_ms    <= stamp;
    do @(posedge clk); while (!in_if.ready);
    sb.note_poll(ab[1], ab[0], btn, stamp);
    sent_phase = phase;
    clock_ms   = stamp;
  endtask

  // Stop polling and let every owed result come out, plus the pipeline depth.
  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_idle();
    @(negedge clk);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= data;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_register(idx, data);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // New random settings, extremes favored; upper data bits carry junk the
  // block must mask off.
  task automatic shuffle_config();
    logic [15:0] tmo;
    logic [2:0]  thr;
    case ($urandom_range(0, 3))
      0:       tmo = 16'd0;
      1:       tmo = 16'hFFFF;
      2:       tmo = 16'($urandom_range(1, 60));
      default: tmo = 16'($urandom);
    endcase
    thr = ($urandom_range(0, 3) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
    cfg_write(REG_IDLE_TIMEOUT, tmo);
    cfg_write(REG_STEP_THRESH, {13'($urandom), thr});
    cfg_write(REG_INVERT_DIR, {15'($urandom), 1'($urandom)});
  endtask

  // Random polls: mostly clean rotation runs with dwell, some illegal jumps,
  // some idle gaps past the timeout, and some pure noise.
  task automatic random_polls(int count);
    logic [1:0]        phase;
    logic [TIME_W-1:0] stamp;
    int                pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 6) stamp = clock_ms + $urandom_range(0, 70000);
      else stamp = clock_ms + $urandom_range(0, 30);
      if (pick < 4) begin
        // noise: any lines, any timestamp (also pushes the clock across its wrap)
        phase = 2'($urandom);
        stamp = $urandom;
      end else if (pick < 8) begin
        phase = sent_phase + 2'd2;
      end else begin
        if (run_left == 0) begin
          run_dir  = $urandom_range(0, 1) ? 1 : -1;
          run_left = $urandom_range(1, 12);
        end
        if ($urandom_range(0, 99) < 30) begin
          phase = sent_phase;                  // dwell on the same phase
        end else begin
          phase = (run_dir > 0) ? sent_phase + 2'd1 : sent_phase - 2'd1;
          run_left--;
        end
      end
      send_poll(phase, 1'($urandom), stamp);
    end
  endtask

  initial begin
    sb            = new();
    send_idle_pct = 6;
    recv_idle_pct = 79;
    cycle_count   = 0;
    sent_phase    = 2'd0;
    clock_ms      = '0;
    run_dir       = 1;
    run_left      = 0;

    // Every input known from time zero.
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.chan_a     = 1'b0;
    in_if.chan_b     = 1'b0;
    in_if.button_in  = 1'b0;
    in_if.now_ms     = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.reg_index = REG_IDLE_TIMEOUT;
    cfg_if.wdata     = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- Directed: reset settings (timeout 500, threshold 2, inverted) ----
    send_poll(2'd0, 1'b1, 32'd0);            // no motion
    send_poll(2'd1, 1'b0, 32'd5);            // three forward steps exceed 2:
    send_poll(2'd2, 1'b1, 32'd10);
    send_poll(2'd3, 1'b0, 32'd15);           //   inverted -> position down
    send_poll(2'd0, 1'b1, 32'd20);
    send_poll(2'd3, 1'b0, 32'd25);           // backward run
    send_poll(2'd2, 1'b1, 32'd30);
    send_poll(2'd1, 1'b0, 32'd35);
    send_poll(2'd0, 1'b1, 32'd40);
    send_poll(2'd2, 1'b0, 32'd45);           // illegal double jump counts forward
    send_poll(2'd0, 1'b1, 32'd50);
    send_poll(2'd0, 1'b0, 32'd551);          // idle past the timeout clears partial count
    send_poll(2'd1, 1'b1, 32'hFFFF_FFF0);    // timestamp about to wrap
    send_poll(2'd1, 1'b0, 32'h0000_0005);    // elapsed measured across the wrap
    send_poll(2'd3, 1'b1, 32'hFFFF_FFFF);

    // Unused slot, then zero threshold, normal direction, zero timeout.
    cfg_write(REG_UNUSED, 16'($urandom));
    cfg_write(REG_STEP_THRESH, 16'hFFF8);
    cfg_write(REG_INVERT_DIR, 16'hFFFE);
    cfg_write(REG_IDLE_TIMEOUT, 16'd0);
    send_poll(2'd0, 1'b0, 32'd100);          // every live step moves a detent
    send_poll(2'd1, 1'b1, 32'd100);
    send_poll(2'd0, 1'b0, 32'd101);
    send_poll(2'd0, 1'b1, 32'd102);          // one ms of dwell already times out

    // Threshold 7 behaves as 6; widest timeout.
    cfg_write(REG_STEP_THRESH, 16'hFFFF);
    cfg_write(REG_IDLE_TIMEOUT, 16'hFFFF);
    for (int i = 1; i <= 7; i++)
      send_poll(2'(i), 1'(i), 32'(200 + i));
    send_poll(2'd3, 1'b0, 32'd207 + 32'd65535);  // exactly at the timeout: kept
    send_poll(2'd3, 1'b1, 32'd207 + 32'd65536);  // one past: cleared

    // ---- Random: three idle patterns, settings reshuffled between blocks ----
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 6;  recv_idle_pct = 79; end
        1: begin send_idle_pct = 79; recv_idle_pct = 6;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int blk = 0; blk < 4; blk++) begin
        shuffle_config();
        random_polls(105);
      end
    end

    wait_idle();

    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
